### rtl/ofrh_pkg.sv
package ofrh_pkg;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;

  localparam int unsigned MIX_SHIFT_A   = 30;
  localparam int unsigned MIX_SHIFT_B   = 27;
  localparam int unsigned MIX_SHIFT_OUT = 31;

  // one classified sample on its way from the front to the mixer
  typedef struct packed {
    logic [63:0] word;
    logic        resident;
    logic        last;
  } item_t;

endpackage

### rtl/ofrh_front.sv
module ofrh_front (
  input  logic [14:0]    sample_index_i,
  input  logic [15:0]    sample_value_i,
  input  logic [15:0]    sample_material_i,
  input  logic           region_resident_i,
  input  logic           last_sample_i,
  output ofrh_pkg::item_t item_o
);
  import ofrh_pkg::*;

  logic [63:0] tuple;

  // index in 46..32, raw value in 31..16, material in 15..0
  assign tuple = {17'd0, sample_index_i, sample_value_i, sample_material_i};

  assign item_o.word     = tuple + GOLDEN_GAMMA;
  assign item_o.resident = region_resident_i;
  assign item_o.last     = last_sample_i;

endmodule

### rtl/ofrh_fifo.sv
module ofrh_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ofrh_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output ofrh_pkg::item_t head_item_o
);
  import ofrh_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  item_t            slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o       = (count_q == FULL_CNT);
  assign head_valid_o = (count_q != '0);
  assign head_item_o  = slots_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### rtl/ofrh_back.sv
module ofrh_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  ofrh_pkg::item_t head_item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [63:0]     region_hash_o
);
  import ofrh_pkg::*;

  // partial products of a 64x64 multiply, low 64 bits only
  typedef struct packed {
    logic [63:0] lo_lo;
    logic [31:0] hi_lo;
    logic [31:0] lo_hi;
    logic        resident;
    logic        last;
  } part_t;

  typedef struct packed {
    logic [63:0] word;
    logic        resident;
    logic        last;
  } word_t;

  logic        adv;
  logic        v1_q, v2_q, v3_q, v4_q;
  part_t       s1_q, s1_d, s3_q, s3_d;
  word_t       s2_q, s2_d, s4_q, s4_d;
  logic [63:0] x1, x3, z;
  logic [63:0] sum_q, sum_d;
  logic        all_res_q, all_res_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] hash_q;

  // only a finished region waiting on a full output register holds the line
  assign adv   = !(v4_q && s4_q.last && out_valid_q && !out_ready_i);
  assign pop_o = adv && head_valid_i;

  always_comb begin
    x1 = head_item_i.word ^ (head_item_i.word >> MIX_SHIFT_A);
    s1_d.lo_lo    = 64'(x1[31:0]) * 64'(MIX_MUL_A[31:0]);
    s1_d.hi_lo    = x1[63:32] * MIX_MUL_A[31:0];
    s1_d.lo_hi    = x1[31:0] * MIX_MUL_A[63:32];
    s1_d.resident = head_item_i.resident;
    s1_d.last     = head_item_i.last;

    s2_d.word     = s1_q.lo_lo + {s1_q.hi_lo + s1_q.lo_hi, 32'd0};
    s2_d.resident = s1_q.resident;
    s2_d.last     = s1_q.last;

    x3 = s2_q.word ^ (s2_q.word >> MIX_SHIFT_B);
    s3_d.lo_lo    = 64'(x3[31:0]) * 64'(MIX_MUL_B[31:0]);
    s3_d.hi_lo    = x3[63:32] * MIX_MUL_B[31:0];
    s3_d.lo_hi    = x3[31:0] * MIX_MUL_B[63:32];
    s3_d.resident = s2_q.resident;
    s3_d.last     = s2_q.last;

    z = s3_q.lo_lo + {s3_q.hi_lo + s3_q.lo_hi, 32'd0};
    s4_d.word     = z ^ (z >> MIX_SHIFT_OUT);
    s4_d.resident = s3_q.resident;
    s4_d.last     = s3_q.last;
  end

  always_comb begin
    sum_d       = sum_q;
    all_res_d   = all_res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (adv && v4_q) begin
      sum_d     = sum_q + s4_q.word;
      all_res_d = all_res_q && s4_q.resident;
      if (s4_q.last) begin
        out_valid_d = 1'b1;
        sum_d       = '0;
        all_res_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      sum_q       <= '0;
      all_res_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        v1_q <= head_valid_i;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
      end
      sum_q       <= sum_d;
      all_res_q   <= all_res_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
    if (adv && v4_q && s4_q.last) begin
      hash_q <= (all_res_q && s4_q.resident) ? sum_q + s4_q.word : 64'd0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign region_hash_o = hash_q;

endmodule

### rtl/order_free_region_hash.sv
// Order-free region hash.
// Samples of one region stream in on the input channel (valid/ready), one
// item per cycle while in_ready_o is high. Each sample's tuple {index,
// value, material} is offset by the golden-ratio constant, run through the
// splitmix64 finaliser and added into a 64-bit wrapping sum. The item flagged
// last_sample closes the region: one result item carries the sum, or zero if
// any item of the region had region_resident low. Items without the last
// flag give no result. Throughput: one item per cycle while the output is
// not backed up. The front classifies and writes a small queue; the back is
// a four-stage mixer (two 64-bit multiplies, each split into 32x32 partial
// products, then a partial-sum add) and the accumulator feeding an output
// register that holds each result after the last item leaves the mixer.
// Stall: while a result waits in the output register, the mixer keeps going
// until a second region closes; then the mixer holds, the queue fills and
// in_ready_o drops. Nothing is lost or repeated.
// Reset: queue empty, mixer empty, sum zero, residency flag set, no result.
module order_free_region_hash #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [14:0] sample_index_i,
  input  logic [15:0] sample_value_i,
  input  logic [15:0] sample_material_i,
  input  logic        region_resident_i,
  input  logic        last_sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] region_hash_o
);
  import ofrh_pkg::*;

  item_t front_item;
  item_t head_item;
  logic  fifo_full;
  logic  head_valid;
  logic  pop;

  ofrh_front u_front (
    .sample_index_i    (sample_index_i),
    .sample_value_i    (sample_value_i),
    .sample_material_i (sample_material_i),
    .region_resident_i (region_resident_i),
    .last_sample_i     (last_sample_i),
    .item_o            (front_item)
  );

  // decouples intake from the mixer so either side may stall
  ofrh_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i),
    .push_item_i  (front_item),
    .full_o       (fifo_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_item_o  (head_item)
  );

  assign in_ready_o = !fifo_full;

  ofrh_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_item_i   (head_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .region_hash_o (region_hash_o)
  );

endmodule

### sim/order_free_region_hash_test.sv
module order_free_region_hash_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ofrh_pkg::*;

  // Region hash scoreboard: keeps a private copy of the running sum and the
  // residency flag, and queues the hash due for each region closed so far.
  class region_hash_board;
    logic [63:0] due_hashes[$];
    logic [63:0] open_sum;
    logic        open_resident;
    int unsigned errors;

    function new();
      open_sum      = '0;
      open_resident = 1'b1;
      errors        = 0;
    endfunction

    // splitmix64 finaliser on the offset tuple
    function logic [63:0] mix_tuple(logic [14:0] idx, logic [15:0] val,
                                    logic [15:0] mat);
      logic [63:0] w;
      w = {17'd0, idx, val, mat} + GOLDEN_GAMMA;
      w = (w ^ (w >> MIX_SHIFT_A)) * MIX_MUL_A;
      w = (w ^ (w >> MIX_SHIFT_B)) * MIX_MUL_B;
      return w ^ (w >> MIX_SHIFT_OUT);
    endfunction

    function void note_sample(logic [14:0] idx, logic [15:0] val,
                              logic [15:0] mat, logic resident, logic last);
      open_sum = open_sum + mix_tuple(idx, val, mat);
      if (!resident) open_resident = 1'b0;
      if (last) begin
        due_hashes.push_back(open_resident ? open_sum : 64'd0);
        open_sum      = '0;
        open_resident = 1'b1;
      end
    endfunction

    function void check_hash(logic [63:0] actual);
      logic [63:0] want;
      if (due_hashes.size() == 0) begin
        $display("%0t: unexpected result, actual region_hash %h", $realtime, actual);
        errors++;
      end else begin
        want = due_hashes.pop_front();
        if (actual !== want) begin
          $display("%0t: region_hash expected %h actual %h", $realtime, want, actual);
          errors++;
        end
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // ---------------------------------------------------------------------
  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic        in_ready_o;
  logic [14:0] sample_index_i    = '0;
  logic [15:0] sample_value_i    = '0;
  logic [15:0] sample_material_i = '0;
  logic        region_resident_i = 1'b1;
  logic        last_sample_i     = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i       = 1'b0;
  logic [63:0] region_hash_o;

  region_hash_board sb = new();

  // idling odds in percent, set per phase by the main sequence
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // long receiver hold-off: requested by the main sequence, counted below
  int unsigned hold_request   = 0;
  int unsigned hold_left      = 0;

  order_free_region_hash dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .sample_index_i    (sample_index_i),
    .sample_value_i    (sample_value_i),
    .sample_material_i (sample_material_i),
    .region_resident_i (region_resident_i),
    .last_sample_i     (last_sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .region_hash_o     (region_hash_o)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver: ready changes on the falling edge. A hold-off request parks
  // ready low, counted down in hold_left, so results back up into the block.
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor: sampled on the rising edge, handshake from pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_hash(region_hash_o);
  end

  // Offer one sample; entered and left on a falling edge. Idle cycles come
  // first, with valid low; once raised, valid and the payload hold until the
  // item is taken.
  task automatic send_sample(input logic [14:0] idx, input logic [15:0] val,
                             input logic [15:0] mat, input logic resident,
                             input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    sample_index_i    <= idx;
    sample_value_i    <= val;
    sample_material_i <= mat;
    region_resident_i <= resident;
    last_sample_i     <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(idx, val, mat, resident, last);
    @(negedge clk_i);
  endtask

  // One region of random samples; the last one carries the flag.
  // Non-residency is rare per item so most regions give a real sum.
  task automatic send_region(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_sample(15'($urandom_range(32767)), 16'($urandom_range(65535)),
                  16'($urandom_range(65535)),
                  $urandom_range(99) >= 3, i == len - 1);
    end
  endtask

  // Mostly short regions so results are frequent; now and then a long one.
  task automatic send_random_regions(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned roll;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 80)      len = $urandom_range(8, 1);
      else if (roll < 98) len = $urandom_range(40, 9);
      else                len = $urandom_range(150, 60);
      send_region(len);
      sent += len;
    end
  endtask

  // Lower valid, let every due hash arrive, then let the mixer settle.
  task automatic drain_hashes();
    in_valid_i <= 1'b0;
    while (sb.due_hashes.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // --- directed ---
    // single-item regions at the field extremes
    send_sample(15'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1);
    send_sample(15'h7fff, 16'hffff, 16'hffff, 1'b1, 1'b1);
    // single item, not resident: zero
    send_sample(15'h7fff, 16'hffff, 16'hffff, 1'b0, 1'b1);
    // non-residency in the middle of a region
    send_sample(15'h2aaa, 16'h5555, 16'haaaa, 1'b1, 1'b0);
    send_sample(15'h5555, 16'haaaa, 16'h5555, 1'b0, 1'b0);
    send_sample(15'h0001, 16'h8000, 16'h0001, 1'b1, 1'b1);
    // non-residency only on the last item
    send_sample(15'h1234, 16'h0fed, 16'hcba9, 1'b1, 1'b0);
    send_sample(15'h4321, 16'hf00f, 16'h0ff0, 1'b0, 1'b1);
    // repeated index: same sample twice, both summed
    send_sample(15'h0100, 16'h7fff, 16'h8000, 1'b1, 1'b0);
    send_sample(15'h0100, 16'h7fff, 16'h8000, 1'b1, 1'b1);
    // same samples in reverse order must give the same hash
    send_sample(15'h0003, 16'h0002, 16'h0001, 1'b1, 1'b0);
    send_sample(15'h7ffe, 16'hfffe, 16'hfffd, 1'b1, 1'b1);
    send_sample(15'h7ffe, 16'hfffe, 16'hfffd, 1'b1, 1'b0);
    send_sample(15'h0003, 16'h0002, 16'h0001, 1'b1, 1'b1);
    // residency flag must have been restored after a zeroed region
    send_sample(15'h0000, 16'hffff, 16'h0000, 1'b0, 1'b1);
    send_sample(15'h7fff, 16'h0000, 16'hffff, 1'b1, 1'b1);
    drain_hashes();

    // --- random, one idling pattern per phase ---
    set_idling(0, 0);
    send_random_regions(400);
    drain_hashes();

    set_idling(72, 0);
    send_random_regions(350);
    drain_hashes();

    set_idling(0, 72);
    send_random_regions(400);
    drain_hashes();

    set_idling(35, 35);
    send_random_regions(400);
    drain_hashes();

    // back-pressure: receiver parked while short regions keep coming, so the
    // output register and the mixer fill and the input stalls
    set_idling(0, 0);
    hold_request = 400;
    for (int unsigned r = 0; r < 120; r++) send_region($urandom_range(3, 1));
    drain_hashes();

    set_idling(0, 0);
    send_random_regions(150);
    drain_hashes();

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
